@@ rtl/sdc_pkg.sv @@
package sdc_pkg;

    localparam int SLOT_COUNT         = 4;
    localparam int PERIOD_MS          = 100;
    localparam int ERROR_HOLD_PERIODS = 100;

    localparam int SLOT_REGS   = 4;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DAY_MIN_W   = 11;
    localparam int ACCUM_W     = 17;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAX_INIT_TRIES      = 3'd0,
        REG_DISPENSE_PERIODS    = 3'd1,
        REG_IDLE_BLINK_HALF     = 3'd2,
        REG_DISPENSE_BLINK_HALF = 3'd3,
        REG_SLOT_ZERO           = 3'd4,
        REG_SLOT_ONE            = 3'd5,
        REG_SLOT_TWO            = 3'd6,
        REG_SLOT_THREE          = 3'd7
    } cfg_reg_t;

    localparam logic [3:0]           MAX_INIT_TRIES_RST = 4'd3;
    localparam logic [15:0]          DISPENSE_PERIODS_RST = 16'd30;
    localparam logic [15:0]          IDLE_HALF_RST = 16'd50;
    localparam logic [15:0]          DISPENSE_HALF_RST = 16'd100;
    localparam logic [DAY_MIN_W-1:0] SLOT_ZERO_RST = 11'd481;
    localparam logic [DAY_MIN_W-1:0] SLOT_ONE_RST = 11'd780;
    localparam logic [DAY_MIN_W-1:0] SLOT_TWO_RST = 11'd1080;
    localparam logic [DAY_MIN_W-1:0] SLOT_THREE_RST = 11'd1320;

    localparam logic [5:0]         SLOT_WINDOW_S = 6'd5;
    localparam logic [5:0]         MINUTES_PER_HOUR = 6'd60;
    localparam logic [3:0]         TRY_LIMIT = 4'hF;
    localparam logic [15:0]        PERIODS_LIMIT = 16'hFFFF;
    localparam logic [7:0]         ERROR_LIMIT = 8'hFF;
    localparam logic [7:0]         ERROR_HOLD = 8'(ERROR_HOLD_PERIODS);
    localparam logic [ACCUM_W-1:0] BLINK_STEP = ACCUM_W'(PERIOD_MS);

    localparam logic CAUSE_BUTTON = 1'b0;
    localparam logic CAUSE_SLOT   = 1'b1;

    typedef enum logic [3:0] {
        MODE_INIT  = 4'b0001,
        MODE_IDLE  = 4'b0010,
        MODE_DISP  = 4'b0100,
        MODE_ERROR = 4'b1000
    } mode_t;

    localparam logic [1:0] STATE_CODE_INIT  = 2'd0;
    localparam logic [1:0] STATE_CODE_IDLE  = 2'd1;
    localparam logic [1:0] STATE_CODE_DISP  = 2'd2;
    localparam logic [1:0] STATE_CODE_ERROR = 2'd3;

    typedef struct packed {
        logic       clock_start_ok;
        logic       clock_set_ok;
        logic       clock_read_ok;
        logic [4:0] now_hour;
        logic [5:0] now_minute;
        logic [5:0] now_second;
        logic       button_pressed;
    } item_t;

    typedef struct packed {
        logic [1:0] state_code;
        logic       motor_on;
        logic       led_on;
        logic       dispense_started;
        logic       dispense_cause;
        logic       reset_request;
    } result_t;

    typedef struct packed {
        logic hit;
        logic early;
    } slot_match_t;

    function automatic logic [1:0] mode_code(mode_t m);
        logic [1:0] code;
        unique case (m)
            MODE_INIT:  code = STATE_CODE_INIT;
            MODE_IDLE:  code = STATE_CODE_IDLE;
            MODE_DISP:  code = STATE_CODE_DISP;
            MODE_ERROR: code = STATE_CODE_ERROR;
            default:    code = STATE_CODE_INIT;
        endcase
        return code;
    endfunction

endpackage

@@ rtl/sdc_item_if.sv @@
interface sdc_item_if;
    logic       valid;
    logic       ready;
    logic       clock_start_ok;
    logic       clock_set_ok;
    logic       clock_read_ok;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
    logic       button_pressed;

    modport source (
        output valid, clock_start_ok, clock_set_ok, clock_read_ok,
               now_hour, now_minute, now_second, button_pressed,
        input  ready
    );

    modport sink (
        input  valid, clock_start_ok, clock_set_ok, clock_read_ok,
               now_hour, now_minute, now_second, button_pressed,
        output ready
    );
endinterface

@@ rtl/sdc_result_if.sv @@
interface sdc_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] state_code;
    logic       motor_on;
    logic       led_on;
    logic       dispense_started;
    logic       dispense_cause;
    logic       reset_request;

    modport source (
        output valid, state_code, motor_on, led_on, dispense_started,
               dispense_cause, reset_request,
        input  ready
    );

    modport sink (
        input  valid, state_code, motor_on, led_on, dispense_started,
               dispense_cause, reset_request,
        output ready
    );
endinterface

@@ rtl/scheduled_dispense_controller.sv @@
// Channel   Direction  Payload
// item      in         clock_start_ok, clock_set_ok, clock_read_ok, now_hour,
//                      now_minute, now_second, button_pressed
// result    out        state_code, motor_on, led_on, dispense_started,
//                      dispense_cause, reset_request
// cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// One transaction is accepted per cycle unless the result stalls; its result
// goes to the result register when it advances and is offered from then on.
// The input register and the result register each hold one transaction, and
// the state update between them is combinational.
// An asynchronous active-low reset returns the controller to init and the
// configuration and state registers to their default values.
// A stalled result holds the pipeline; the input side stays ready while the
// input register is empty or advancing.
module scheduled_dispense_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    sdc_item_if.sink                          item,
    sdc_result_if.source                      result,
    input  logic                              cfg_we,
    input  logic [sdc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sdc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sdc_pkg::*;

    logic [3:0]                             max_tries_reg;
    logic [15:0]                            disp_periods_reg;
    logic [15:0]                            idle_half_reg;
    logic [15:0]                            disp_half_reg;
    logic [SLOT_REGS-1:0][DAY_MIN_W-1:0]    slot_reg;

    item_t         item_reg;
    logic          item_valid_reg;
    result_t       result_reg;
    result_t       result_next;
    logic          result_valid_reg;
    logic          advance;
    logic          item_accept;

    mode_t              mode_reg, mode_next;
    logic [3:0]         try_reg, try_next;
    logic               fired_reg, fired_next;
    logic [4:0]         fired_hour_reg, fired_hour_next;
    logic [5:0]         fired_minute_reg, fired_minute_next;
    logic [15:0]        periods_reg, periods_next;
    logic               running_reg, running_next;
    logic [ACCUM_W-1:0] accum_reg, accum_next;
    logic               led_reg, led_next;
    logic [7:0]         error_reg, error_next;
    logic               cause_reg, cause_next;
    logic               started;
    logic               request;
    logic [15:0]        half;
    logic [ACCUM_W-1:0] accum_sum;
    slot_match_t        match;

    assign advance     = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready  = !item_valid_reg || advance;
    assign item_accept = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tries_reg    <= MAX_INIT_TRIES_RST;
            disp_periods_reg <= DISPENSE_PERIODS_RST;
            idle_half_reg    <= IDLE_HALF_RST;
            disp_half_reg    <= DISPENSE_HALF_RST;
            slot_reg[0]      <= SLOT_ZERO_RST;
            slot_reg[1]      <= SLOT_ONE_RST;
            slot_reg[2]      <= SLOT_TWO_RST;
            slot_reg[3]      <= SLOT_THREE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAX_INIT_TRIES:      max_tries_reg    <= cfg_data[3:0];
                REG_DISPENSE_PERIODS:    disp_periods_reg <= cfg_data;
                REG_IDLE_BLINK_HALF:     idle_half_reg    <= cfg_data;
                REG_DISPENSE_BLINK_HALF: disp_half_reg    <= cfg_data;
                REG_SLOT_ZERO:           slot_reg[0]      <= cfg_data[DAY_MIN_W-1:0];
                REG_SLOT_ONE:            slot_reg[1]      <= cfg_data[DAY_MIN_W-1:0];
                REG_SLOT_TWO:            slot_reg[2]      <= cfg_data[DAY_MIN_W-1:0];
                REG_SLOT_THREE:          slot_reg[3]      <= cfg_data[DAY_MIN_W-1:0];
                default:                 max_tries_reg    <= max_tries_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            item_reg.clock_start_ok <= item.clock_start_ok;
            item_reg.clock_set_ok   <= item.clock_set_ok;
            item_reg.clock_read_ok  <= item.clock_read_ok;
            item_reg.now_hour       <= item.now_hour;
            item_reg.now_minute     <= item.now_minute;
            item_reg.now_second     <= item.now_second;
            item_reg.button_pressed <= item.button_pressed;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    sdc_slot_match u_slot_match (
        .slot_minute (slot_reg[SLOT_COUNT-1:0]),
        .now_hour    (item_reg.now_hour),
        .now_minute  (item_reg.now_minute),
        .now_second  (item_reg.now_second),
        .match       (match)
    );

    always_comb
    begin
        mode_next         = mode_reg;
        try_next          = try_reg;
        fired_next        = fired_reg;
        fired_hour_next   = fired_hour_reg;
        fired_minute_next = fired_minute_reg;
        periods_next      = periods_reg;
        running_next      = running_reg;
        accum_next        = accum_reg;
        led_next          = led_reg;
        error_next        = error_reg;
        cause_next        = cause_reg;
        started           = 1'b0;
        request           = 1'b0;
        half              = idle_half_reg;
        accum_sum         = '0;

        unique case (mode_reg)
            MODE_INIT:
            begin
                if (item_reg.clock_start_ok)
                begin
                    if (item_reg.clock_set_ok)
                    begin
                        try_next  = '0;
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        mode_next = MODE_ERROR;
                    end
                end
                else
                begin
                    if (try_reg != TRY_LIMIT)
                    begin
                        try_next = try_reg + 4'd1;
                    end
                    if (try_next >= max_tries_reg)
                    begin
                        mode_next = MODE_ERROR;
                    end
                end
            end
            MODE_IDLE:
            begin
                if (item_reg.button_pressed)
                begin
                    cause_next = CAUSE_BUTTON;
                    mode_next  = MODE_DISP;
                    accum_next = '0;
                end
                else if (item_reg.clock_read_ok)
                begin
                    if (!match.hit)
                    begin
                        fired_next = 1'b0;
                    end
                    else if (match.early
                             && !(fired_reg
                                  && fired_hour_reg == item_reg.now_hour
                                  && fired_minute_reg == item_reg.now_minute))
                    begin
                        fired_next        = 1'b1;
                        fired_hour_next   = item_reg.now_hour;
                        fired_minute_next = item_reg.now_minute;
                        cause_next        = CAUSE_SLOT;
                        mode_next         = MODE_DISP;
                        accum_next        = '0;
                    end
                end
            end
            MODE_DISP:
            begin
                if (!running_reg)
                begin
                    running_next = 1'b1;
                    periods_next = '0;
                    started      = 1'b1;
                end
                else if (periods_reg != PERIODS_LIMIT)
                begin
                    periods_next = periods_reg + 16'd1;
                end
                if (periods_next >= disp_periods_reg)
                begin
                    running_next = 1'b0;
                    mode_next    = MODE_IDLE;
                    accum_next   = '0;
                end
            end
            MODE_ERROR:
            begin
                led_next = 1'b1;
                if (error_reg != ERROR_LIMIT)
                begin
                    error_next = error_reg + 8'd1;
                end
                request = error_next >= ERROR_HOLD;
            end
            default:
            begin
                mode_next = MODE_INIT;
            end
        endcase

        // The LED accumulator runs only in idle and while dispensing.
        if (mode_next == MODE_IDLE || mode_next == MODE_DISP)
        begin
            half      = (mode_next == MODE_IDLE) ? idle_half_reg : disp_half_reg;
            accum_sum = accum_next + BLINK_STEP;
            if (accum_sum >= ACCUM_W'(half))
            begin
                led_next   = !led_next;
                accum_next = '0;
            end
            else
            begin
                accum_next = accum_sum;
            end
        end

        result_next.state_code       = mode_code(mode_next);
        result_next.motor_on         = running_next;
        result_next.led_on           = led_next;
        result_next.dispense_started = started;
        result_next.dispense_cause   = cause_next;
        result_next.reset_request    = request;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            mode_reg         <= MODE_INIT;
            try_reg          <= '0;
            fired_reg        <= 1'b0;
            fired_hour_reg   <= '0;
            fired_minute_reg <= '0;
            periods_reg      <= '0;
            running_reg      <= 1'b0;
            accum_reg        <= '0;
            led_reg          <= 1'b0;
            error_reg        <= '0;
            cause_reg        <= CAUSE_BUTTON;
        end
        else
        begin
            if (item.ready)
            begin
                item_valid_reg <= item.valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                mode_reg         <= mode_next;
                try_reg          <= try_next;
                fired_reg        <= fired_next;
                fired_hour_reg   <= fired_hour_next;
                fired_minute_reg <= fired_minute_next;
                periods_reg      <= periods_next;
                running_reg      <= running_next;
                accum_reg        <= accum_next;
                led_reg          <= led_next;
                error_reg        <= error_next;
                cause_reg        <= cause_next;
            end
        end
    end

    assign result.valid            = result_valid_reg;
    assign result.state_code       = result_reg.state_code;
    assign result.motor_on         = result_reg.motor_on;
    assign result.led_on           = result_reg.led_on;
    assign result.dispense_started = result_reg.dispense_started;
    assign result.dispense_cause   = result_reg.dispense_cause;
    assign result.reset_request    = result_reg.reset_request;

    mode_onehot_a: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(mode_reg))
    else $error("Controller state is not one-hot.");

    motor_only_dispensing_a: assert property (@(posedge clk) disable iff (!rst_n)
        running_reg |-> mode_reg == MODE_DISP)
    else $error("Motor runs outside the dispensing state.");

    error_absorbing_a: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_ERROR |=> mode_reg == MODE_ERROR)
    else $error("Controller left the error state without a reset.");

    request_in_error_a: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.reset_request |-> result.state_code == STATE_CODE_ERROR)
    else $error("Reset request raised outside the error state.");

    idle_empty_a: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
    else $error("Advanced transaction did not reach the result register.");

endmodule

@@ rtl/sdc_slot_match.sv @@
module sdc_slot_match (
    input  logic [sdc_pkg::SLOT_COUNT-1:0][sdc_pkg::DAY_MIN_W-1:0] slot_minute,
    input  logic [4:0]                                             now_hour,
    input  logic [5:0]                                             now_minute,
    input  logic [5:0]                                             now_second,
    output sdc_pkg::slot_match_t                                   match
);
    import sdc_pkg::*;

    logic [DAY_MIN_W-1:0] day_minute;
    logic                 minute_ok;
    logic                 any_hit;

    // Hour times sixty is formed as hour times sixty-four less hour times four.
    assign day_minute = DAY_MIN_W'({now_hour, 6'b0}) - DAY_MIN_W'({now_hour, 2'b0})
                        + DAY_MIN_W'(now_minute);
    assign minute_ok  = now_minute < MINUTES_PER_HOUR;

    always_comb
    begin
        any_hit = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (slot_minute[i] == day_minute)
            begin
                any_hit = 1'b1;
            end
        end
    end

    assign match.hit   = any_hit && minute_ok;
    assign match.early = now_second < SLOT_WINDOW_S;

endmodule

@@ test/scheduled_dispense_controller_tb.sv @@
module scheduled_dispense_controller_tb;
    import sdc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    class status_scoreboard;
        logic [3:0]           max_tries;
        logic [15:0]          run_periods;
        logic [15:0]          idle_half;
        logic [15:0]          run_half;
        logic [DAY_MIN_W-1:0] slot_min [SLOT_REGS];

        logic [1:0]           mode;
        logic [3:0]           tries;
        logic                 slot_fired;
        logic [4:0]           fired_hour;
        logic [5:0]           fired_minute;
        logic [15:0]          motor_periods;
        logic                 motor_running;
        logic [ACCUM_W-1:0]   blink_accum;
        logic                 led_level;
        logic [7:0]           error_periods;
        logic                 cause;

        result_t              expected_status [$];
        int                   failures;

        function new();
            max_tries = MAX_INIT_TRIES_RST;
            run_periods = DISPENSE_PERIODS_RST;
            idle_half = IDLE_HALF_RST;
            run_half = DISPENSE_HALF_RST;
            slot_min[0] = SLOT_ZERO_RST;
            slot_min[1] = SLOT_ONE_RST;
            slot_min[2] = SLOT_TWO_RST;
            slot_min[3] = SLOT_THREE_RST;
            mode = STATE_CODE_INIT;
            tries = '0;
            slot_fired = 1'b0;
            fired_hour = '0;
            fired_minute = '0;
            motor_periods = '0;
            motor_running = 1'b0;
            blink_accum = '0;
            led_level = 1'b0;
            error_periods = '0;
            cause = CAUSE_BUTTON;
            failures = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_MAX_INIT_TRIES:      max_tries = val[3:0];
                REG_DISPENSE_PERIODS:    run_periods = val;
                REG_IDLE_BLINK_HALF:     idle_half = val;
                REG_DISPENSE_BLINK_HALF: run_half = val;
                default:                 slot_min[idx - REG_SLOT_ZERO] = val[DAY_MIN_W-1:0];
            endcase
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void accept_item(item_t it);
            result_t want;
            logic    started;
            logic    request;
            logic    decided;
            logic    in_slot;
            logic    hit;
            logic [15:0] half;
            int      k;
            started = 1'b0;
            request = 1'b0;
            decided = 1'b0;
            in_slot = 1'b0;
            hit = 1'b0;
            case (mode)
                STATE_CODE_INIT:
                begin
                    if (it.clock_start_ok)
                    begin
                        if (it.clock_set_ok)
                        begin
                            tries = '0;
                            mode = STATE_CODE_IDLE;
                        end
                        else
                        begin
                            mode = STATE_CODE_ERROR;
                        end
                    end
                    else
                    begin
                        if (tries != TRY_LIMIT)
                            tries = tries + 4'd1;
                        if (tries >= max_tries)
                            mode = STATE_CODE_ERROR;
                    end
                end
                STATE_CODE_IDLE:
                begin
                    if (it.button_pressed)
                    begin
                        cause = CAUSE_BUTTON;
                        mode = STATE_CODE_DISP;
                        blink_accum = '0;
                    end
                    else if (it.clock_read_ok)
                    begin
                        for (k = 0; k < SLOT_COUNT; k++)
                        begin
                            if (!decided
                                && int'(it.now_hour) == int'(slot_min[k]) / int'(MINUTES_PER_HOUR)
                                && int'(it.now_minute) == int'(slot_min[k]) % int'(MINUTES_PER_HOUR))
                            begin
                                if (it.now_second < SLOT_WINDOW_S)
                                begin
                                    decided = 1'b1;
                                    if (!(slot_fired && fired_hour == it.now_hour
                                          && fired_minute == it.now_minute))
                                    begin
                                        slot_fired = 1'b1;
                                        fired_hour = it.now_hour;
                                        fired_minute = it.now_minute;
                                        hit = 1'b1;
                                    end
                                end
                                else
                                begin
                                    in_slot = 1'b1;
                                end
                            end
                        end
                        if (!decided && !in_slot)
                            slot_fired = 1'b0;
                        if (hit)
                        begin
                            cause = CAUSE_SLOT;
                            mode = STATE_CODE_DISP;
                            blink_accum = '0;
                        end
                    end
                end
                STATE_CODE_DISP:
                begin
                    if (!motor_running)
                    begin
                        motor_running = 1'b1;
                        motor_periods = '0;
                        started = 1'b1;
                    end
                    else if (motor_periods != PERIODS_LIMIT)
                    begin
                        motor_periods = motor_periods + 16'd1;
                    end
                    if (motor_periods >= run_periods)
                    begin
                        motor_running = 1'b0;
                        mode = STATE_CODE_IDLE;
                        blink_accum = '0;
                    end
                end
                default:
                begin
                    led_level = 1'b1;
                    if (error_periods != ERROR_LIMIT)
                        error_periods = error_periods + 8'd1;
                    if (error_periods >= ERROR_HOLD)
                        request = 1'b1;
                end
            endcase

            if (mode == STATE_CODE_IDLE || mode == STATE_CODE_DISP)
            begin
                half = (mode == STATE_CODE_IDLE) ? idle_half : run_half;
                blink_accum = blink_accum + BLINK_STEP;
                if (blink_accum >= {1'b0, half})
                begin
                    led_level = ~led_level;
                    blink_accum = '0;
                end
            end

            want.state_code = mode;
            want.motor_on = motor_running;
            want.led_on = led_level;
            want.dispense_started = started;
            want.dispense_cause = cause;
            want.reset_request = request;
            expected_status.push_back(want);
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            failures++;
        endfunction

        function void check_status(result_t got);
            result_t want;
            if (expected_status.size() == 0)
            begin
                $display("%0t: status transaction %h arrived with none expected", $time, got);
                failures++;
                return;
            end
            want = expected_status.pop_front();
            if (want.state_code != got.state_code)
                report("state_code", want.state_code, got.state_code);
            if (want.motor_on != got.motor_on)
                report("motor_on", want.motor_on, got.motor_on);
            if (want.led_on != got.led_on)
                report("led_on", want.led_on, got.led_on);
            if (want.dispense_started != got.dispense_started)
                report("dispense_started", want.dispense_started, got.dispense_started);
            if (want.dispense_cause != got.dispense_cause)
                report("dispense_cause", want.dispense_cause, got.dispense_cause);
            if (want.reset_request != got.reset_request)
                report("reset_request", want.reset_request, got.reset_request);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    bit   no_idle;
    int   cycle_count;

    status_scoreboard status_board;

    sdc_item_if   item_ch ();
    sdc_result_if result_ch ();

    scheduled_dispense_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic bit take_gap();
        return !no_idle && $urandom_range(99) < 33;
    endfunction

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready = !take_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            status_board.check_status('{result_ch.state_code, result_ch.motor_on,
                                        result_ch.led_on, result_ch.dispense_started,
                                        result_ch.dispense_cause, result_ch.reset_request});
    end

    function automatic item_t at_time(input logic read_ok, input int hh, input int mm,
                                      input int ss, input logic button);
        item_t it;
        it.clock_start_ok = 1'($urandom_range(1));
        it.clock_set_ok = 1'($urandom_range(1));
        it.clock_read_ok = read_ok;
        it.now_hour = 5'(hh);
        it.now_minute = 6'(mm);
        it.now_second = 6'(ss);
        it.button_pressed = button;
        return it;
    endfunction

    function automatic item_t random_item(input bit quiet);
        item_t it;
        int    pick;
        it.clock_start_ok = 1'($urandom_range(1));
        it.clock_set_ok = 1'($urandom_range(1));
        it.clock_read_ok = ($urandom_range(99) < 85);
        it.button_pressed = !quiet && ($urandom_range(99) < 8);
        if (!quiet && $urandom_range(99) < 55)
        begin
            pick = status_board.slot_min[$urandom_range(SLOT_COUNT - 1)];
            it.now_hour = 5'(pick / 60);
            it.now_minute = 6'(pick % 60);
            if ($urandom_range(99) < 70)
                it.now_second = 6'($urandom_range(7));
            else
                it.now_second = 6'($urandom_range(59));
        end
        else
        begin
            it.now_hour = 5'($urandom_range(23));
            it.now_minute = 6'($urandom_range(59));
            it.now_second = 6'($urandom_range(59));
        end
        return it;
    endfunction

    task automatic send_item(input item_t it);
        while (take_gap())
        begin
            item_ch.valid = 1'b0;
            @(negedge clk);
        end
        item_ch.valid = 1'b1;
        item_ch.clock_start_ok = it.clock_start_ok;
        item_ch.clock_set_ok = it.clock_set_ok;
        item_ch.clock_read_ok = it.clock_read_ok;
        item_ch.now_hour = it.now_hour;
        item_ch.now_minute = it.now_minute;
        item_ch.now_second = it.now_second;
        item_ch.button_pressed = it.button_pressed;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        status_board.accept_item(it);
        @(negedge clk);
    endtask

    task automatic drain();
        item_ch.valid = 1'b0;
        while (status_board.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        status_board.set_reg(idx, val);
    endtask

    task automatic apply_settings(input logic [3:0] tries, input logic [15:0] periods,
                                  input logic [15:0] idle_ms, input logic [15:0] run_ms);
        int k;
        drain();
        write_reg(REG_MAX_INIT_TRIES, tries);
        write_reg(REG_DISPENSE_PERIODS, periods);
        write_reg(REG_IDLE_BLINK_HALF, idle_ms);
        write_reg(REG_DISPENSE_BLINK_HALF, run_ms);
        for (k = 0; k < SLOT_REGS; k++)
            write_reg(cfg_reg_t'(REG_SLOT_ZERO + k), CFG_DATA_W'($urandom_range(1439)));
    endtask

    task automatic run_random(input int count, input bit quiet);
        repeat (count) send_item(random_item(quiet));
    endtask

    initial
    begin
        item_t it;
        int    p;
        status_board = new();
        cycle_count = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MAX_INIT_TRIES;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.clock_start_ok = 1'b0;
        item_ch.clock_set_ok = 1'b0;
        item_ch.clock_read_ok = 1'b0;
        item_ch.now_hour = '0;
        item_ch.now_minute = '0;
        item_ch.now_second = '0;
        item_ch.button_pressed = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        write_reg(REG_MAX_INIT_TRIES, 16'd15);
        write_reg(REG_DISPENSE_PERIODS, 16'd0);
        write_reg(REG_SLOT_ZERO, 16'd0);
        write_reg(REG_SLOT_THREE, 16'd1439);

        // Fourteen failed start-ups stay just below the retry limit.
        repeat (14)
        begin
            it = random_item(1'b0);
            it.clock_start_ok = 1'b0;
            send_item(it);
        end
        it = random_item(1'b0);
        it.clock_start_ok = 1'b1;
        it.clock_set_ok = 1'b1;
        send_item(it);

        send_item(at_time(1'b1, 12, 0, 30, 1'b1));
        send_item(at_time(1'b1, 0, 0, 0, 1'b1));
        send_item(at_time(1'b1, 0, 0, 0, 1'b0));
        send_item(at_time(1'b1, 0, 0, 1, 1'b0));
        send_item(at_time(1'b1, 0, 0, 2, 1'b0));
        send_item(at_time(1'b1, 0, 0, 5, 1'b0));
        send_item(at_time(1'b0, 23, 59, 4, 1'b0));
        send_item(at_time(1'b1, 23, 59, 4, 1'b0));
        send_item(at_time(1'b1, 23, 59, 0, 1'b0));
        send_item(at_time(1'b1, 10, 30, 59, 1'b0));
        send_item(at_time(1'b1, 23, 59, 3, 1'b0));
        send_item(at_time(1'b1, 16, 59, 59, 1'b0));
        send_item(at_time(1'b1, 23, 59, 4, 1'b1));
        send_item(at_time(1'b1, 23, 59, 4, 1'b0));
        send_item(at_time(1'b1, 23, 59, 2, 1'b0));

        for (p = 0; p < 8; p++)
        begin
            case (p)
                0:
                begin
                    apply_settings(4'd1, 16'd2, 16'd1, 16'd1);
                    no_idle = 1'b1;
                    run_random(300, 1'b0);
                    no_idle = 1'b0;
                end
                1:
                begin
                    apply_settings(4'($urandom_range(1, 15)), 16'd0, 16'd100, 16'd200);
                    run_random(300, 1'b0);
                end
                2:
                begin
                    apply_settings(4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                    run_random(150, 1'b0);
                end
                3:
                begin
                    // A long quiet idle stretch lets the widest half period toggle the LED.
                    apply_settings(4'd3, 16'd3, 16'hFFFF, 16'd1);
                    run_random(680, 1'b1);
                end
                default:
                begin
                    apply_settings(4'($urandom_range(1, 15)), 16'($urandom_range(12)),
                                   16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)));
                    if (p == 5)
                        write_reg(REG_SLOT_ONE, CFG_DATA_W'(status_board.slot_min[0]));
                    run_random(130, 1'b0);
                end
            endcase
        end

        drain();
        repeat (6) @(negedge clk);
        if (status_board.failures == 0 && status_board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

@@ scheduled_dispense_controller.f @@
rtl/sdc_pkg.sv
rtl/sdc_item_if.sv
rtl/sdc_result_if.sv
rtl/sdc_slot_match.sv
rtl/scheduled_dispense_controller.sv
test/scheduled_dispense_controller_tb.sv
